// ===== hdl/fcw_pkg.sv =====
// shared constants, codes and types of the four character word machine
package fcw_pkg;

  localparam int MEM_WORDS   = 100;
  localparam int CARD_CHARS  = 40;
  localparam int BLOCK_WORDS = 10;

  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam int CNT_W  = 7;
  localparam int CC_W   = $clog2(CARD_CHARS + 1);
  localparam int DATA_W = 32;
  localparam int BYTE_W = 8;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;

  localparam logic [CNT_W-1:0] MEM_LIM  = CNT_W'(MEM_WORDS);
  localparam logic [CC_W-1:0]  CARD_LIM = CC_W'(CARD_CHARS);

  localparam logic [BYTE_W-1:0] CH_G    = 8'h47;
  localparam logic [BYTE_W-1:0] CH_P    = 8'h50;
  localparam logic [BYTE_W-1:0] CH_H    = 8'h48;
  localparam logic [BYTE_W-1:0] CH_L    = 8'h4C;
  localparam logic [BYTE_W-1:0] CH_S    = 8'h53;
  localparam logic [BYTE_W-1:0] CH_C    = 8'h43;
  localparam logic [BYTE_W-1:0] CH_B    = 8'h42;
  localparam logic [BYTE_W-1:0] CH_D    = 8'h44;
  localparam logic [BYTE_W-1:0] CH_R    = 8'h52;
  localparam logic [BYTE_W-1:0] CH_T    = 8'h54;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

  typedef enum logic [ACT_W-1:0] {
    ACT_INIT  = 3'd0,
    ACT_PCHAR = 3'd1,
    ACT_PEND  = 3'd2,
    ACT_START = 3'd3,
    ACT_STEP  = 3'd4,
    ACT_DCHAR = 3'd5,
    ACT_DEND  = 3'd6
  } act_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_WAIT    = 3'd1,
    STAT_HALT    = 3'd2,
    STAT_UNKNOWN = 3'd3,
    STAT_FAULT   = 3'd4,
    STAT_IDLE    = 3'd5
  } stat_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_WAIT = 2'd2,
    MODE_HALT = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MERGE,
    S_FETCH,
    S_OPER,
    S_PD_RD,
    S_PD_BYTE,
    S_RESP
  } fsm_e;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] cmp;
    logic [BYTE_W-1:0] value;
    logic [1:0]        sel;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] merged;
    logic [BYTE_W-1:0] byte_v;
    logic              eq;
  } alu_rsp_t;

endpackage

// ===== hdl/fcw_if.sv =====
// valid/ready channel interfaces for input and result items
interface fcw_in_if import fcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] char_in;

  modport source (output valid, output action, output char_in, input ready);
  modport sink   (input valid, input action, input char_in, output ready);
endinterface

interface fcw_out_if import fcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              out_valid;
  logic [BYTE_W-1:0] out_char;
  logic              line_end;
  logic              last;
  logic [CNT_W-1:0]  counter_out;
  logic              carry_out;

  modport source (output valid, output status, output out_valid, output out_char,
                  output line_end, output last, output counter_out, output carry_out,
                  input ready);
  modport sink   (input valid, input status, input out_valid, input out_char,
                  input line_end, input last, input counter_out, input carry_out,
                  output ready);
endinterface

// ===== hdl/fcw_ram.sv =====
// generic single write port ram with registered read
module fcw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fcw_alu.sv =====
// shared byte merge, byte extract and word compare unit
module fcw_alu import fcw_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  always_comb begin
    rsp_o.merged = req_i.word;
    rsp_o.byte_v = '0;
    unique case (req_i.sel)
      2'd0: begin
        rsp_o.merged[31:24] = req_i.value;
        rsp_o.byte_v        = req_i.word[31:24];
      end
      2'd1: begin
        rsp_o.merged[23:16] = req_i.value;
        rsp_o.byte_v        = req_i.word[23:16];
      end
      2'd2: begin
        rsp_o.merged[15:8] = req_i.value;
        rsp_o.byte_v       = req_i.word[15:8];
      end
      default: begin
        rsp_o.merged[7:0] = req_i.value;
        rsp_o.byte_v      = req_i.word[7:0];
      end
    endcase
    rsp_o.eq = (req_i.word == req_i.cmp);
  end

endmodule

// ===== hdl/four_char_word_machine.sv =====
// four character word machine: sequencer, word store and result register
//
// Items arrive on in_i (action, char_in) and results leave on out_o, both
// valid/ready channels; an item is taken when valid and ready are both high.
// in_i.ready is high only while the sequencer is idle, so one item is worked
// at a time. Every item gives one result with last set, except PD, which
// gives one result per non-null printed byte and then a line-end result.
// Each item is decoded in a dispatch state and answered from a result state:
// init, card end, start, refused and dropped items go straight there, a
// stored program or data character first reads, merges and writes its word,
// a step first fetches its instruction and LR and CR also read an operand.
// The next item can be taken in the cycle of the earliest result handshake.
// PD reads each word of its block and takes its bytes in turn, each printed
// byte a result of its own. The word store is a 100 word ram, read registered;
// each word carries a valid flop, so reset and init clear the store at once.
// Reset clears the machine state and the valid flag of the result register.
// The last result sits in an output register: the next item is accepted
// while it waits. When the receiver stalls, a later result holds the
// sequencer until the register is taken.
module four_char_word_machine import fcw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcw_in_if.sink     in_i,
  fcw_out_if.source  out_o
);

  fsm_e fsm_q, fsm_d;

  logic [ACT_W-1:0]  act_q, act_d;
  logic [BYTE_W-1:0] ch_q, ch_d;
  logic [CNT_W-1:0]  ic_q, ic_d;
  logic [DATA_W-1:0] reg_q, reg_d;
  logic              carry_q, carry_d;
  logic [1:0]        bp_q, bp_d;
  logic [CC_W-1:0]   cc_q, cc_d;
  logic [CNT_W-1:0]  dp_q, dp_d;
  mode_e             mode_q, mode_d;
  logic [MEM_WORDS-1:0] vld_q, vld_d;
  stat_e             rs_q, rs_d;
  logic              rle_q, rle_d;
  logic [ADDR_W-1:0] wa_q, wa_d;
  logic [1:0]        bsel_q, bsel_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  stop_q, stop_d;
  logic              cmp_op_q, cmp_op_d;
  logic              vld_rd_q;

  // result register
  logic              oq_valid_q;
  logic [STAT_W-1:0] oq_status_q;
  logic              oq_outv_q;
  logic [BYTE_W-1:0] oq_char_q;
  logic              oq_le_q;
  logic              oq_last_q;
  logic [CNT_W-1:0]  oq_cnt_q;
  logic              oq_carry_q;

  // ram and shared unit
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata, rd_word;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  // emit
  logic              emit_req, emit_fire, slot_free;
  stat_e             em_status;
  logic              em_outv, em_le, em_last;
  logic [BYTE_W-1:0] em_char;

  // decode helpers
  logic              in_fire;
  logic              cc_room, ic_in, dw_in;
  logic [CNT_W-1:0]  dw;
  logic [BYTE_W-1:0] op0, op1, hi, lo;
  logic [3:0]        hi_dig, lo_dig, blk;
  logic              digits_ok, addr_ok;
  logic [CNT_W-1:0]  loc, stop_raw, stop_cap, idx_nxt;
  logic              is_h, is_bt, is_g, is_p, is_l, is_s, is_c, known;

  fcw_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fcw_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // a word never written since reset or init reads as zero
  assign rd_word = vld_rd_q ? ram_rdata : '0;

  assign in_fire   = in_i.valid && in_i.ready;
  assign slot_free = !oq_valid_q || out_o.ready;
  assign emit_fire = emit_req && slot_free;

  assign cc_room = (cc_q < CARD_LIM);
  assign ic_in   = (ic_q < MEM_LIM);
  assign dw      = dp_q + CNT_W'(cc_q >> 2);
  assign dw_in   = (dw < MEM_LIM);

  assign op0 = rd_word[31:24];
  assign op1 = rd_word[23:16];
  assign hi  = rd_word[15:8];
  assign lo  = rd_word[7:0];

  assign digits_ok = (hi >= CH_ZERO) && (hi <= CH_NINE) &&
                     (lo >= CH_ZERO) && (lo <= CH_NINE);
  assign hi_dig   = 4'(hi - CH_ZERO);
  assign lo_dig   = 4'(lo - CH_ZERO);
  assign loc      = CNT_W'(hi_dig * BLOCK_WORDS) + CNT_W'(lo_dig);
  assign addr_ok  = digits_ok && (loc < MEM_LIM);
  // end of the ten word block holding loc, clipped to the store
  assign blk      = hi_dig + 4'd1;
  assign stop_raw = CNT_W'(blk * BLOCK_WORDS);
  assign stop_cap = (stop_raw > MEM_LIM) ? MEM_LIM : stop_raw;
  assign idx_nxt  = idx_q + CNT_W'(1);

  assign is_h  = (op0 == CH_H);
  assign is_bt = (op0 == CH_B) && (op1 == CH_T);
  assign is_g  = (op0 == CH_G);
  assign is_p  = (op0 == CH_P);
  assign is_l  = (op0 == CH_L);
  assign is_s  = (op0 == CH_S);
  assign is_c  = (op0 == CH_C);
  assign known = ((op1 == CH_D) && (is_g || is_p)) ||
                 ((op1 == CH_R) && (is_l || is_s || is_c));

  // next state
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      S_IDLE: begin
        if (in_fire) fsm_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        fsm_d = S_RESP;
        unique case (act_q)
          ACT_PCHAR: begin
            if (cc_room && (ch_q != '0) && ic_in) fsm_d = S_MERGE;
          end
          ACT_STEP: begin
            if ((mode_q == MODE_RUN) && ic_in) fsm_d = S_FETCH;
          end
          ACT_DCHAR: begin
            if ((mode_q == MODE_WAIT) && cc_room && dw_in) fsm_d = S_MERGE;
          end
          default: fsm_d = S_RESP;
        endcase
      end
      S_MERGE: fsm_d = S_RESP;
      S_FETCH: begin
        if (!is_h && !is_bt && known && addr_ok) begin
          if (is_p) begin
            fsm_d = S_PD_RD;
          end else if (is_l || is_c) begin
            fsm_d = S_OPER;
          end else begin
            fsm_d = S_RESP;
          end
        end else begin
          fsm_d = S_RESP;
        end
      end
      S_OPER:  fsm_d = S_RESP;
      S_PD_RD: fsm_d = S_PD_BYTE;
      S_PD_BYTE: begin
        if ((alu_rsp.byte_v == '0) || emit_fire) begin
          if (bsel_q == 2'd3) begin
            fsm_d = (idx_nxt == stop_q) ? S_RESP : S_PD_RD;
          end
        end
      end
      S_RESP: begin
        if (emit_fire) fsm_d = S_IDLE;
      end
      default: fsm_d = S_IDLE;
    endcase
  end

  // outputs: ram, shared unit and result requests
  always_comb begin
    in_i.ready = (fsm_q == S_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = wa_q;
    ram_wdata  = alu_rsp.merged;
    ram_re     = 1'b0;
    ram_raddr  = ic_q[ADDR_W-1:0];
    alu_req.word  = rd_word;
    alu_req.cmp   = reg_q;
    alu_req.value = ch_q;
    alu_req.sel   = bsel_q;
    emit_req  = 1'b0;
    em_status = rs_q;
    em_outv   = 1'b0;
    em_char   = '0;
    em_le     = rle_q;
    em_last   = 1'b1;
    unique case (fsm_q)
      S_DISPATCH: begin
        unique case (act_q)
          ACT_PCHAR: begin
            ram_re    = cc_room && (ch_q != '0) && ic_in;
            ram_raddr = ic_q[ADDR_W-1:0];
          end
          ACT_STEP: begin
            ram_re    = (mode_q == MODE_RUN) && ic_in;
            ram_raddr = ic_q[ADDR_W-1:0];
          end
          ACT_DCHAR: begin
            ram_re    = (mode_q == MODE_WAIT) && cc_room && dw_in;
            ram_raddr = dw[ADDR_W-1:0];
          end
          default: ram_re = 1'b0;
        endcase
      end
      S_MERGE: ram_we = 1'b1;
      S_FETCH: begin
        if (!is_h && !is_bt && known && addr_ok) begin
          ram_re    = is_l || is_c;
          ram_raddr = loc[ADDR_W-1:0];
          ram_we    = is_s;
          ram_waddr = loc[ADDR_W-1:0];
          ram_wdata = reg_q;
        end
      end
      S_PD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q[ADDR_W-1:0];
      end
      S_PD_BYTE: begin
        emit_req  = (alu_rsp.byte_v != '0);
        em_status = STAT_OK;
        em_outv   = 1'b1;
        em_char   = alu_rsp.byte_v;
        em_le     = 1'b0;
        em_last   = 1'b0;
      end
      S_RESP: emit_req = 1'b1;
      default: emit_req = 1'b0;
    endcase
  end

  // machine state updates
  always_comb begin
    act_d    = act_q;
    ch_d     = ch_q;
    ic_d     = ic_q;
    reg_d    = reg_q;
    carry_d  = carry_q;
    bp_d     = bp_q;
    cc_d     = cc_q;
    dp_d     = dp_q;
    mode_d   = mode_q;
    vld_d    = vld_q;
    rs_d     = rs_q;
    rle_d    = rle_q;
    wa_d     = wa_q;
    bsel_d   = bsel_q;
    idx_d    = idx_q;
    stop_d   = stop_q;
    cmp_op_d = cmp_op_q;
    unique case (fsm_q)
      S_IDLE: begin
        if (in_fire) begin
          act_d = in_i.action;
          ch_d  = in_i.char_in;
        end
      end
      S_DISPATCH: begin
        rs_d  = STAT_OK;
        rle_d = 1'b0;
        unique case (act_q)
          ACT_INIT: begin
            ic_d    = '0;
            reg_d   = '0;
            carry_d = 1'b0;
            bp_d    = '0;
            cc_d    = '0;
            dp_d    = '0;
            mode_d  = MODE_IDLE;
            vld_d   = '0;
          end
          ACT_PCHAR: begin
            if (cc_room) begin
              if (ch_q == '0) begin
                // a null byte ends loading for the rest of the card
                cc_d = CARD_LIM;
              end else begin
                cc_d   = cc_q + CC_W'(1);
                wa_d   = ic_q[ADDR_W-1:0];
                bsel_d = bp_q;
              end
            end
          end
          ACT_PEND: begin
            bp_d = '0;
            cc_d = '0;
          end
          ACT_START: begin
            ic_d   = '0;
            mode_d = MODE_RUN;
          end
          ACT_STEP: begin
            if (mode_q == MODE_WAIT) begin
              rs_d = STAT_WAIT;
            end else if (mode_q != MODE_RUN) begin
              rs_d = STAT_IDLE;
            end else if (!ic_in) begin
              rs_d = STAT_FAULT;
            end else begin
              ic_d = ic_q + CNT_W'(1);
            end
          end
          ACT_DCHAR: begin
            if (mode_q != MODE_WAIT) begin
              rs_d = STAT_IDLE;
            end else begin
              rs_d = STAT_WAIT;
              if (cc_room) begin
                cc_d   = cc_q + CC_W'(1);
                wa_d   = dw[ADDR_W-1:0];
                bsel_d = cc_q[1:0];
              end
            end
          end
          ACT_DEND: begin
            if (mode_q != MODE_WAIT) begin
              rs_d = STAT_IDLE;
            end else begin
              cc_d   = '0;
              mode_d = MODE_RUN;
            end
          end
          default: rs_d = STAT_OK;
        endcase
      end
      S_MERGE: begin
        vld_d[wa_q] = 1'b1;
        if (act_q == ACT_PCHAR) begin
          bp_d = bp_q + 2'd1;
          if (bp_q == 2'd3) ic_d = ic_q + CNT_W'(1);
        end
      end
      S_FETCH: begin
        rs_d = STAT_OK;
        if (is_h) begin
          mode_d = MODE_HALT;
          rs_d   = STAT_HALT;
          rle_d  = 1'b1;
        end else if (is_bt) begin
          if (carry_q) begin
            if (!addr_ok) begin
              rs_d = STAT_FAULT;
            end else begin
              ic_d = loc;
            end
          end
        end else if (!known) begin
          rs_d = STAT_UNKNOWN;
        end else if (!addr_ok) begin
          rs_d = STAT_FAULT;
        end else if (is_g) begin
          dp_d   = loc;
          cc_d   = '0;
          mode_d = MODE_WAIT;
          rs_d   = STAT_WAIT;
        end else if (is_p) begin
          idx_d  = loc;
          stop_d = stop_cap;
          bsel_d = '0;
          rle_d  = 1'b1;
        end else if (is_s) begin
          vld_d[loc[ADDR_W-1:0]] = 1'b1;
        end else begin
          cmp_op_d = is_c;
        end
      end
      S_OPER: begin
        if (cmp_op_q) begin
          carry_d = alu_rsp.eq;
        end else begin
          reg_d = rd_word;
        end
      end
      S_PD_RD: bsel_d = '0;
      S_PD_BYTE: begin
        if ((alu_rsp.byte_v == '0) || emit_fire) begin
          bsel_d = bsel_q + 2'd1;
          if (bsel_q == 2'd3) idx_d = idx_nxt;
        end
      end
      default: rs_d = rs_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q      <= S_IDLE;
      ic_q       <= '0;
      reg_q      <= '0;
      carry_q    <= 1'b0;
      bp_q       <= '0;
      cc_q       <= '0;
      dp_q       <= '0;
      mode_q     <= MODE_IDLE;
      vld_q      <= '0;
      oq_valid_q <= 1'b0;
    end else begin
      fsm_q   <= fsm_d;
      ic_q    <= ic_d;
      reg_q   <= reg_d;
      carry_q <= carry_d;
      bp_q    <= bp_d;
      cc_q    <= cc_d;
      dp_q    <= dp_d;
      mode_q  <= mode_d;
      vld_q   <= vld_d;
      if (emit_fire) begin
        oq_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        oq_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    ch_q     <= ch_d;
    rs_q     <= rs_d;
    rle_q    <= rle_d;
    wa_q     <= wa_d;
    bsel_q   <= bsel_d;
    idx_q    <= idx_d;
    stop_q   <= stop_d;
    cmp_op_q <= cmp_op_d;
    if (ram_re) begin
      vld_rd_q <= vld_q[ram_raddr];
    end
    if (emit_fire) begin
      oq_status_q <= em_status;
      oq_outv_q   <= em_outv;
      oq_char_q   <= em_char;
      oq_le_q     <= em_le;
      oq_last_q   <= em_last;
      oq_cnt_q    <= ic_q;
      oq_carry_q  <= carry_q;
    end
  end

  assign out_o.valid       = oq_valid_q;
  assign out_o.status      = oq_status_q;
  assign out_o.out_valid   = oq_outv_q;
  assign out_o.out_char    = oq_char_q;
  assign out_o.line_end    = oq_le_q;
  assign out_o.last        = oq_last_q;
  assign out_o.counter_out = oq_cnt_q;
  assign out_o.carry_out   = oq_carry_q;

endmodule

// ===== sim/fcw_checker.sv =====
// result predictor and checker for the four character word machine
`timescale 1ns / 100ps

module fcw_checker import fcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  fcw_in_if    in_mon,
  fcw_out_if   out_mon,
  output int   error_cnt,
  output int   pending_cnt,
  output int   item_cnt,
  output int   result_cnt
);

  localparam int DEC_BASE   = 10;
  localparam int SHOW_LIMIT = 20;
  localparam logic [BYTE_W-1:0] NUL_CHAR = 8'h00;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              out_valid;
    logic [BYTE_W-1:0] out_char;
    logic              line_end;
    logic              last;
    logic [CNT_W-1:0]  counter;
    logic              carry;
  } machine_result_t;

  // machine copy
  logic [DATA_W-1:0] store [MEM_WORDS];
  logic [CNT_W-1:0]  icount;
  logic [DATA_W-1:0] acc;
  logic              carry;
  logic [1:0]        byte_pos;
  int                chars_taken;
  int                data_ptr;
  mode_e             mode;

  machine_result_t item_results[$];
  machine_result_t expected_results[$];

  task automatic clear_machine();
    foreach (store[i]) store[i] = '0;
    icount      = '0;
    acc         = '0;
    carry       = 1'b0;
    byte_pos    = '0;
    chars_taken = 0;
    data_ptr    = 0;
    mode        = MODE_IDLE;
  endtask

  task automatic note_result(input logic [STAT_W-1:0] st, input logic ov,
                             input logic [BYTE_W-1:0] ch, input logic le);
    machine_result_t r;
    r = '0;
    r.status    = st;
    r.out_valid = ov;
    r.out_char  = ch;
    r.line_end  = le;
    item_results.push_back(r);
  endtask

  task automatic execute_instruction();
    logic [DATA_W-1:0] ir;
    logic [BYTE_W-1:0] op0, op1, hi, lo, c;
    int loc, stop;
    bit addr_ok;
    if (mode != MODE_RUN) begin
      note_result(mode == MODE_WAIT ? STAT_WAIT : STAT_IDLE, 1'b0, NUL_CHAR, 1'b0);
      return;
    end
    if (icount >= MEM_LIM) begin
      note_result(STAT_FAULT, 1'b0, NUL_CHAR, 1'b0);
      return;
    end
    ir = store[icount];
    icount++;
    {op0, op1, hi, lo} = ir;
    addr_ok = hi >= CH_ZERO && hi <= CH_NINE && lo >= CH_ZERO && lo <= CH_NINE;
    loc = addr_ok ? int'(hi - CH_ZERO) * DEC_BASE + int'(lo - CH_ZERO) : 0;
    addr_ok = addr_ok && loc < MEM_WORDS;
    if (op0 == CH_H) begin
      mode = MODE_HALT;
      note_result(STAT_HALT, 1'b0, NUL_CHAR, 1'b1);
      return;
    end
    // branch address only matters when the branch is taken
    if (op0 == CH_B && op1 == CH_T) begin
      if (carry) begin
        if (!addr_ok) begin
          note_result(STAT_FAULT, 1'b0, NUL_CHAR, 1'b0);
          return;
        end
        icount = CNT_W'(loc);
      end
      note_result(STAT_OK, 1'b0, NUL_CHAR, 1'b0);
      return;
    end
    if (!((op1 == CH_D && (op0 == CH_G || op0 == CH_P)) ||
          (op1 == CH_R && (op0 == CH_L || op0 == CH_S || op0 == CH_C)))) begin
      note_result(STAT_UNKNOWN, 1'b0, NUL_CHAR, 1'b0);
      return;
    end
    if (!addr_ok) begin
      note_result(STAT_FAULT, 1'b0, NUL_CHAR, 1'b0);
      return;
    end
    if (op0 == CH_G) begin
      data_ptr    = loc;
      chars_taken = 0;
      mode        = MODE_WAIT;
      note_result(STAT_WAIT, 1'b0, NUL_CHAR, 1'b0);
    end else if (op0 == CH_P) begin
      // print to the end of the ten word block, nulls skipped
      stop = (loc / BLOCK_WORDS + 1) * BLOCK_WORDS;
      if (stop > MEM_WORDS) stop = MEM_WORDS;
      for (int i = loc; i < stop; i++) begin
        for (int b = 0; b < 4; b++) begin
          c = store[i][(3 - b) * BYTE_W +: BYTE_W];
          if (c != NUL_CHAR) note_result(STAT_OK, 1'b1, c, 1'b0);
        end
      end
      note_result(STAT_OK, 1'b0, NUL_CHAR, 1'b1);
    end else begin
      if (op0 == CH_L) acc = store[loc];
      else if (op0 == CH_S) store[loc] = acc;
      else carry = (store[loc] == acc);
      note_result(STAT_OK, 1'b0, NUL_CHAR, 1'b0);
    end
  endtask

  task automatic predict_machine_item(input logic [ACT_W-1:0] act,
                                      input logic [BYTE_W-1:0] ch);
    int w;
    case (act)
      ACT_INIT: begin
        clear_machine();
        note_result(STAT_OK, 1'b0, NUL_CHAR, 1'b0);
      end
      ACT_PCHAR: begin
        if (chars_taken < CARD_CHARS) begin
          if (ch == NUL_CHAR) begin
            chars_taken = CARD_CHARS;
          end else begin
            chars_taken++;
            if (icount < MEM_LIM) begin
              store[icount][(3 - byte_pos) * BYTE_W +: BYTE_W] = ch;
              byte_pos++;
              if (byte_pos == 0) icount++;
            end
          end
        end
        note_result(STAT_OK, 1'b0, NUL_CHAR, 1'b0);
      end
      ACT_PEND: begin
        byte_pos    = '0;
        chars_taken = 0;
        note_result(STAT_OK, 1'b0, NUL_CHAR, 1'b0);
      end
      ACT_START: begin
        icount = '0;
        mode   = MODE_RUN;
        note_result(STAT_OK, 1'b0, NUL_CHAR, 1'b0);
      end
      ACT_STEP: execute_instruction();
      ACT_DCHAR: begin
        if (mode != MODE_WAIT) begin
          note_result(STAT_IDLE, 1'b0, NUL_CHAR, 1'b0);
        end else begin
          if (chars_taken < CARD_CHARS) begin
            w = data_ptr + chars_taken / 4;
            if (w < MEM_WORDS) store[w][(3 - chars_taken % 4) * BYTE_W +: BYTE_W] = ch;
            chars_taken++;
          end
          note_result(STAT_WAIT, 1'b0, NUL_CHAR, 1'b0);
        end
      end
      ACT_DEND: begin
        if (mode != MODE_WAIT) begin
          note_result(STAT_IDLE, 1'b0, NUL_CHAR, 1'b0);
        end else begin
          chars_taken = 0;
          mode        = MODE_RUN;
          note_result(STAT_OK, 1'b0, NUL_CHAR, 1'b0);
        end
      end
      default: note_result(STAT_OK, 1'b0, NUL_CHAR, 1'b0);
    endcase
    // counter and carry are the state after the whole item
    foreach (item_results[k]) begin
      item_results[k].counter = icount;
      item_results[k].carry   = carry;
      item_results[k].last    = (k == item_results.size() - 1);
      expected_results.push_back(item_results[k]);
    end
    item_results.delete();
  endtask

  task automatic check_result();
    machine_result_t seen, want;
    seen = '{status: out_mon.status, out_valid: out_mon.out_valid,
             out_char: out_mon.out_char, line_end: out_mon.line_end,
             last: out_mon.last, counter: out_mon.counter_out,
             carry: out_mon.carry_out};
    result_cnt++;
    if (expected_results.size() == 0) begin
      error_cnt++;
      if (error_cnt <= SHOW_LIMIT)
        $display("%0t: unexpected result st=%0d ov=%0d ch=%02h le=%0d last=%0d ic=%0d c=%0d",
                 $time, seen.status, seen.out_valid, seen.out_char, seen.line_end,
                 seen.last, seen.counter, seen.carry);
      return;
    end
    want = expected_results.pop_front();
    if (seen !== want) begin
      error_cnt++;
      if (error_cnt <= SHOW_LIMIT)
        $display({"%0t: mismatch, expected st=%0d ov=%0d ch=%02h le=%0d last=%0d ic=%0d c=%0d,",
                  " got st=%0d ov=%0d ch=%02h le=%0d last=%0d ic=%0d c=%0d"},
                 $time, want.status, want.out_valid, want.out_char, want.line_end,
                 want.last, want.counter, want.carry,
                 seen.status, seen.out_valid, seen.out_char, seen.line_end,
                 seen.last, seen.counter, seen.carry);
    end
  endtask

  initial begin
    error_cnt   = 0;
    pending_cnt = 0;
    item_cnt    = 0;
    result_cnt  = 0;
  end

  // input side first: a result never leaves in the cycle its item is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_machine();
      item_results.delete();
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        item_cnt++;
        predict_machine_item(in_mon.action, in_mon.char_in);
      end
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending_cnt = expected_results.size();
  end

endmodule

// ===== sim/tb.sv =====
// testbench top: clock, reset, item stimulus, receiver and verdict
`timescale 1ns / 100ps

module tb;
  import fcw_pkg::*;

  localparam logic [ACT_W-1:0]  ACT_SPARE = 3'd7;
  localparam logic [BYTE_W-1:0] NUL_CHAR  = 8'h00;
  localparam int HOLD_CYCLES  = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic clk_i;
  logic rst_ni;

  fcw_in_if  in_if();
  fcw_out_if out_if();

  int error_cnt, pending_cnt, item_cnt, result_cnt;
  int items_sent  = 0;
  int hold_reqs   = 0;
  int holds_done  = 0;
  int quiet_cycles = 0;
  bit idle_on     = 1'b1;

  four_char_word_machine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  fcw_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .error_cnt   (error_cnt),
    .pending_cnt (pending_cnt),
    .item_cnt    (item_cnt),
    .result_cnt  (result_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [BYTE_W-1:0] rnd_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] ch);
    while (idle_on && $urandom_range(0, 99) < 9) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.action  <= act;
    in_if.char_in <= ch;
    @(negedge clk_i);
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  // four card characters, byte 0 first
  task automatic send_chars(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] w);
    for (int b = 3; b >= 0; b--) send_item(act, w[b * BYTE_W +: BYTE_W]);
  endtask

  task automatic step_machine(input int n);
    repeat (n) send_item(ACT_STEP, rnd_byte());
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_reqs > holds_done) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(0, 99) < 9);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.action  <= ACT_INIT;
    in_if.char_in <= NUL_CHAR;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle machine: step, stray data and the spare action
    send_item(ACT_INIT, NUL_CHAR);
    step_machine(1);
    send_item(ACT_DCHAR, 8'hFF);
    send_item(ACT_DEND, NUL_CHAR);
    send_item(ACT_SPARE, 8'hFF);

    // full first card plus one character past the card limit, no idling
    idle_on = 1'b0;
    send_chars(ACT_PCHAR, "GD30");
    send_chars(ACT_PCHAR, "PD30");
    send_chars(ACT_PCHAR, "LR30");
    send_chars(ACT_PCHAR, "SR45");
    send_chars(ACT_PCHAR, "CR45");
    send_chars(ACT_PCHAR, "BTA1");
    send_chars(ACT_PCHAR, "BT07");
    send_chars(ACT_PCHAR, "XY00");
    send_chars(ACT_PCHAR, "LR9Z");
    send_chars(ACT_PCHAR, "PD00");
    send_item(ACT_PCHAR, 8'hFF);
    send_item(ACT_PEND, NUL_CHAR);
    idle_on = 1'b1;
    // second card ends early on a null byte
    send_chars(ACT_PCHAR, "CR50");
    send_chars(ACT_PCHAR, "BT00");
    send_chars(ACT_PCHAR, "GD95");
    send_chars(ACT_PCHAR, "PD95");
    send_item(ACT_PCHAR, CH_H);
    send_item(ACT_PCHAR, NUL_CHAR);
    send_item(ACT_PCHAR, CH_S);
    send_item(ACT_PEND, NUL_CHAR);

    send_item(ACT_START, NUL_CHAR);
    step_machine(2);
    send_item(ACT_DCHAR, CH_H);
    send_item(ACT_DCHAR, NUL_CHAR);
    send_chars(ACT_DCHAR, "THRE");
    send_item(ACT_DEND, NUL_CHAR);
    step_machine(8);
    // longest print while the receiver holds off and items keep coming
    hold_reqs++;
    step_machine(4);
    // overlong data card that also runs past the last word
    repeat (CARD_CHARS + 1) send_item(ACT_DCHAR, rnd_byte());
    send_item(ACT_DEND, rnd_byte());
    step_machine(3);
    send_item(ACT_PCHAR, 8'h80);
    send_item(ACT_DCHAR, 8'h7F);

    // branch to the last word, fall off the end of memory, load past the end of the store
    send_item(ACT_INIT, rnd_byte());
    send_chars(ACT_PCHAR, "CR50");
    send_chars(ACT_PCHAR, "BT99");
    send_item(ACT_START, rnd_byte());
    step_machine(4);
    send_item(ACT_PCHAR, BYTE_W'($urandom_range(1, 255)));
    in_if.valid <= 1'b0;

    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d items (%0d offered) and %0d results: both card limits,",
             item_cnt, items_sent, result_cnt);
    $display("every instruction and fault, a full block print under a %0d cycle hold-off",
             HOLD_CYCLES);
    if (error_cnt == 0 && pending_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", error_cnt, pending_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
